/* hw/rtl/glr_pkg.sv */
// ----------------------------------------------------------------------------
// glr_pkg
// shared types and constants of the grid line rasterizer
// ----------------------------------------------------------------------------
package glr_pkg;

  localparam int COORD_W = 22;
  localparam int GW_W    = 16;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int LAYER_W = 4;
  localparam int CFG_A_W = 2;

  localparam int DIV_STEPS = COORD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  localparam logic [CFG_A_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_ROW_COUNT    = 2'd2;

  localparam logic [GW_W-1:0]  GRID_WIDTH_RST   = 16'd1;
  localparam logic [CNT_W-1:0] COLUMN_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] ROW_COUNT_RST    = 7'd64;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic               err;
    logic [IDX_W-1:0]   x1;
    logic [IDX_W-1:0]   y1;
    logic [IDX_W-1:0]   major;
    logic [IDX_W-1:0]   minor;
    logic               xneg;
    logic               yneg;
    logic               swap;
  } glr_cmd_t;

endpackage

/* hw/rtl/glr_front.sv */
// ----------------------------------------------------------------------------
// glr_front
// accepts segments, quantizes the four coordinates and classifies the line
// ----------------------------------------------------------------------------
module glr_front #(
  parameter int GRID_DIM = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [glr_pkg::LAYER_W-1:0] layer,
  input  logic [glr_pkg::COORD_W-1:0] start_x,
  input  logic [glr_pkg::COORD_W-1:0] start_y,
  input  logic [glr_pkg::COORD_W-1:0] end_x,
  input  logic [glr_pkg::COORD_W-1:0] end_y,
  input  logic [glr_pkg::GW_W-1:0]    grid_width,
  input  logic [glr_pkg::CNT_W-1:0]   column_count,
  input  logic [glr_pkg::CNT_W-1:0]   row_count,
  output glr_pkg::glr_cmd_t           cmd,
  output logic                       cmd_valid,
  input  logic                       cmd_full
);
  import glr_pkg::*;

  front_state_t state, state_next;

  logic [STEP_W-1:0]  step;
  logic [COORD_W-1:0] num [4];
  logic [GW_W-1:0]    rem [4];
  logic [COORD_W-1:0] num_next [4];
  logic [GW_W-1:0]    rem_next [4];
  logic [LAYER_W-1:0] layer_q;
  logic [GW_W-1:0]    w_eff;

  logic [CNT_W-1:0]   col_lim, row_lim;
  logic [COORD_W-1:0] px1, py1, px2, py2;
  logic [IDX_W-1:0]   x1, y1, x2, y2, ax, ay;
  logic               err, swap;

  function automatic logic [COORD_W-1:0] pull_back(input logic [COORD_W-1:0] idx,
                                                   input logic [CNT_W-1:0] count);
    logic [COORD_W-1:0] cnt_ext;
    cnt_ext = {{(COORD_W-CNT_W){1'b0}}, count};
    if ((count != '0) && (idx == cnt_ext)) begin
      return idx - 1'b1;
    end
    return idx;
  endfunction

  function automatic logic [CNT_W-1:0] limit_of(input logic [CNT_W-1:0] count);
    if (count < CNT_W'(GRID_DIM)) begin
      return count;
    end
    return CNT_W'(GRID_DIM);
  endfunction

  assign w_eff = (grid_width == '0) ? GW_W'(1) : grid_width;

  // restoring divider lanes, one quotient bit per cycle
  always_comb begin
    logic [GW_W:0] trial;
    logic          ge;
    for (int i = 0; i < 4; i++) begin
      trial       = {rem[i], num[i][COORD_W-1]};
      ge          = (trial >= {1'b0, w_eff});
      rem_next[i] = ge ? GW_W'(trial - {1'b0, w_eff}) : trial[GW_W-1:0];
      num_next[i] = {num[i][COORD_W-2:0], ge};
    end
  end

  always_comb begin
    col_lim = limit_of(column_count);
    row_lim = limit_of(row_count);
    px1 = pull_back(num[0], column_count);
    py1 = pull_back(num[1], row_count);
    px2 = pull_back(num[2], column_count);
    py2 = pull_back(num[3], row_count);
    err = (px1 >= {{(COORD_W-CNT_W){1'b0}}, col_lim}) ||
          (px2 >= {{(COORD_W-CNT_W){1'b0}}, col_lim}) ||
          (py1 >= {{(COORD_W-CNT_W){1'b0}}, row_lim}) ||
          (py2 >= {{(COORD_W-CNT_W){1'b0}}, row_lim});
    x1 = px1[IDX_W-1:0];
    y1 = py1[IDX_W-1:0];
    x2 = px2[IDX_W-1:0];
    y2 = py2[IDX_W-1:0];
    ax = (x2 >= x1) ? (x2 - x1) : (x1 - x2);
    ay = (y2 >= y1) ? (y2 - y1) : (y1 - y2);
    swap = (ay > ax);
    cmd.layer = layer_q;
    cmd.err   = err;
    cmd.x1    = x1;
    cmd.y1    = y1;
    cmd.major = swap ? ay : ax;
    cmd.minor = swap ? ax : ay;
    cmd.xneg  = (x2 < x1);
    cmd.yneg  = (y2 < y1);
    cmd.swap  = swap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd_valid  = 1'b0;
    case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_valid = !cmd_full;
        if (!cmd_full) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          num[0]  <= start_x;
          num[1]  <= start_y;
          num[2]  <= end_x;
          num[3]  <= end_y;
          for (int i = 0; i < 4; i++) begin
            rem[i] <= '0;
          end
          step    <= '0;
          layer_q <= layer;
        end
      end
      F_DIV: begin
        for (int i = 0; i < 4; i++) begin
          num[i] <= num_next[i];
          rem[i] <= rem_next[i];
        end
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/glr_queue.sv */
// ----------------------------------------------------------------------------
// glr_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module glr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  glr_pkg::glr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output glr_pkg::glr_cmd_t head,
  output logic              empty
);
  import glr_pkg::*;

  glr_cmd_t          entry [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/glr_back.sv */
// ----------------------------------------------------------------------------
// glr_back
// bresenham stepper, one cell per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module glr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  glr_pkg::glr_cmd_t           head,
  input  logic                        q_empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [glr_pkg::LAYER_W-1:0] cell_layer,
  output logic [glr_pkg::IDX_W-1:0]   cell_col,
  output logic [glr_pkg::IDX_W-1:0]   cell_row,
  output logic                        last_cell,
  output logic                        range_error
);
  import glr_pkg::*;

  localparam int D_W = IDX_W + 3;

  glr_cmd_t               cur;
  logic                   active;
  logic [IDX_W-1:0]       x, y, remaining;
  logic signed [D_W-1:0]  d;
  logic signed [D_W-1:0]  de, dne, d_init, d_next;
  logic [IDX_W-1:0]       x_next, y_next, x_step, y_step;
  logic                   can_load, emit, is_last, straight;

  assign can_load = !out_valid || out_ready;
  assign pop      = !active && !q_empty;
  assign emit     = active && can_load;
  assign is_last  = cur.err || (remaining == '0);

  always_comb begin
    d_init   = $signed({2'b00, head.minor, 1'b0}) - $signed({3'b000, head.major});
    de       = $signed({2'b00, cur.minor, 1'b0});
    dne      = de - $signed({2'b00, cur.major, 1'b0});
    straight = (d <= 0);
    x_step   = cur.xneg ? (x - 1'b1) : (x + 1'b1);
    y_step   = cur.yneg ? (y - 1'b1) : (y + 1'b1);
    if (straight) begin
      x_next = cur.swap ? x : x_step;
      y_next = cur.swap ? y_step : y;
      d_next = d + de;
    end else begin
      x_next = x_step;
      y_next = y_step;
      d_next = d + dne;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end
      if (can_load) begin
        out_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= head;
      x         <= head.x1;
      y         <= head.y1;
      d         <= d_init;
      remaining <= head.major;
    end else if (emit) begin
      cell_layer  <= cur.layer;
      cell_col    <= cur.err ? '0 : x;
      cell_row    <= cur.err ? '0 : y;
      last_cell   <= is_last;
      range_error <= cur.err;
      x           <= x_next;
      y           <= y_next;
      d           <= d_next;
      remaining   <= remaining - 1'b1;
    end
  end

endmodule

/* hw/rtl/grid_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// grid_line_rasterizer
// quantizes segment endpoints to grid cells and walks the cells on the line
// ----------------------------------------------------------------------------
// channel  direction  transfer when          payload
// in       sink       in_valid & in_ready    layer, start_x, start_y, end_x, end_y
// out      source     out_valid & out_ready  cell_layer, cell_col, cell_row,
//                                            last_cell, range_error
// cfg      sink       cfg_valid & cfg_ready  cfg_index, cfg_data
//
// the front accepts a segment, runs the four parallel one-bit-a-cycle
// dividers, then classifies and queues it before it takes the next one
// the back loads a queued line, then emits span + 1 cells, or one for a
// range error, at one per cycle unless stalled; the lines overlap
// reset clears the queue, output and sets grid_width 1, counts 64
// a stalled output holds the stepper; the two-entry queue lets the front run on
module grid_line_rasterizer #(
  parameter int GRID_DIM = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [glr_pkg::LAYER_W-1:0] layer,
  input  logic [glr_pkg::COORD_W-1:0] start_x,
  input  logic [glr_pkg::COORD_W-1:0] start_y,
  input  logic [glr_pkg::COORD_W-1:0] end_x,
  input  logic [glr_pkg::COORD_W-1:0] end_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [glr_pkg::LAYER_W-1:0] cell_layer,
  output logic [glr_pkg::IDX_W-1:0]   cell_col,
  output logic [glr_pkg::IDX_W-1:0]   cell_row,
  output logic                        last_cell,
  output logic                        range_error,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [glr_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [glr_pkg::GW_W-1:0]    cfg_data
);
  import glr_pkg::*;

  logic [GW_W-1:0]  grid_width;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;

  glr_cmd_t push_cmd, head;
  logic     push, q_full, pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_WIDTH_RST;
      column_count <= COLUMN_COUNT_RST;
      row_count    <= ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:   grid_width   <= cfg_data;
        CFG_COLUMN_COUNT: column_count <= cfg_data[CNT_W-1:0];
        CFG_ROW_COUNT:    row_count    <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  glr_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .layer        (layer),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .grid_width   (grid_width),
    .column_count (column_count),
    .row_count    (row_count),
    .cmd          (push_cmd),
    .cmd_valid    (push),
    .cmd_full     (q_full)
  );

  glr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  glr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cell_layer  (cell_layer),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .last_cell   (last_cell),
    .range_error (range_error)
  );

endmodule

/* hw/rtl/glr_checker.sv */
// ----------------------------------------------------------------------------
// glr_checker
// port-level checks of the grid line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
module glr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [glr_pkg::LAYER_W-1:0] cell_layer,
  input logic [glr_pkg::IDX_W-1:0]   cell_col,
  input logic [glr_pkg::IDX_W-1:0]   cell_row,
  input logic                        last_cell,
  input logic                        range_error
);
  import glr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_layer) && $stable(cell_col) &&
      $stable(cell_row) && $stable(last_cell) && $stable(range_error))
    else $error("stalled result changed");

  // error result is a lone origin cell
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last_cell && (cell_col == '0) && (cell_row == '0))
    else $error("malformed range error result");

  // a line continues without a gap on the same layer
  a_line_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_cell |=> out_valid && (cell_layer == $past(cell_layer)))
    else $error("line broken after non-final cell");

  // neighbouring cells of one line touch
  a_line_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_cell |=>
      ((cell_col == $past(cell_col)) || (cell_col == $past(cell_col) + 6'd1) ||
       (cell_col == $past(cell_col) - 6'd1)) &&
      ((cell_row == $past(cell_row)) || (cell_row == $past(cell_row) + 6'd1) ||
       (cell_row == $past(cell_row) - 6'd1)))
    else $error("cells of a line not adjacent");

  // nothing offered straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind grid_line_rasterizer glr_checker u_glr_checker (.*);
